// ===== rtl/rrr_pkg.sv =====
package rrr_pkg;

    localparam int FRAC_BITS = 14;

    localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic [63:0]        HALF    = 64'd1 << (FRAC_BITS - 1);
    localparam logic signed [63:0] OUT_MAX = 64'sd131071;
    localparam logic signed [63:0] OUT_MIN = -64'sd131072;
    localparam logic [16:0]        ETA_MAX = 17'd131071;

    localparam logic OP_REFLECT = 1'b0;
    localparam logic OP_REFRACT = 1'b1;

    typedef logic signed [17:0] comp_t;
    typedef comp_t [2:0] vec_t;

    // running state of a bit-per-stage square root
    typedef struct packed {
        logic [43:0] rem;
        logic [21:0] root;
    } sqrt_st_t;

    // one item as it moves down the pipeline; each stage fills in its own fields
    typedef struct packed {
        logic              op;
        vec_t              d;
        vec_t              n;
        logic [14:0]       from;
        logic [14:0]       to;
        logic              eta_sat;
        logic [29:0]       erem;
        logic [16:0]       eta;
        sqrt_st_t          sq;
        logic              zero_len;
        logic [2:0][31:0]  nrem;
        logic [2:0][14:0]  nq;
        logic [2:0][34:0]  sqn;
        logic [2:0][40:0]  prod;
        logic [2:0][35:0]  edp;
        logic signed [35:0] psum;
        logic signed [20:0] dn;
        logic [33:0]       ee;
        logic [37:0]       cc;
        logic signed [37:0] ec;
        logic [20:0]       eta2;
        logic signed [24:0] t;
        logic signed [22:0] ecr;
        logic [2:0][24:0]  rfl;
        logic [2:0][22:0]  ed;
        logic signed [45:0] s;
        logic              tir;
        logic signed [24:0] k;
        logic [2:0][26:0]  res;
    } item_t;

    // divide by 2^FRAC_BITS, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = (mag + HALF) >> FRAC_BITS;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic comp_t sat18(input logic signed [63:0] v);
        comp_t r;
        if (v > OUT_MAX)
        begin
            r = 18'(OUT_MAX);
        end
        else if (v < OUT_MIN)
        begin
            r = 18'(OUT_MIN);
        end
        else
        begin
            r = 18'(v);
        end
        return r;
    endfunction

    // decide one root bit: (r + 2^b)^2 - r^2 = (r << (b+1)) + 2^(2b)
    function automatic sqrt_st_t isqrt_step(input sqrt_st_t st, input int b);
        logic [45:0] trial;
        sqrt_st_t    r;
        r = st;
        trial = (46'(st.root) << (b + 1)) + (46'd1 << (2 * b));
        if (46'(st.rem) >= trial)
        begin
            r.rem  = 44'(46'(st.rem) - trial);
            r.root = st.root | (22'd1 << b);
        end
        return r;
    endfunction

endpackage

// ===== rtl/rrr_datapath.sv =====
module rrr_datapath
    import rrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_vld,
    input  item_t in_item,
    output logic  out_vld,
    output item_t out_item
);

    localparam int SQ1_STEPS = 18;
    localparam int ETA_STEPS = 17;
    localparam int NRM_STEPS = 15;
    localparam int SQ2_STEPS = 22;

    localparam int ST_IN    = 0;
    localparam int ST_SUM   = ST_IN + 1;
    localparam int SQ1_BASE = ST_SUM + 1;
    localparam int ST_NINIT = SQ1_BASE + SQ1_STEPS;
    localparam int NRM_BASE = ST_NINIT + 1;
    localparam int ST_NSIGN = NRM_BASE + NRM_STEPS;
    localparam int ST_DOT   = ST_NSIGN + 1;
    localparam int ST_PSUM  = ST_DOT + 1;
    localparam int ST_DN    = ST_PSUM + 1;
    localparam int ST_MUL   = ST_DN + 1;
    localparam int ST_RND   = ST_MUL + 1;
    localparam int ST_SIN   = ST_RND + 1;
    localparam int ST_RAD   = ST_SIN + 1;
    localparam int SQ2_BASE = ST_RAD + 1;
    localparam int ST_K     = SQ2_BASE + SQ2_STEPS;
    localparam int ST_KN    = ST_K + 1;
    localparam int ST_RES   = ST_KN + 1;
    localparam int NSTG     = ST_RES + 1;

    item_t            pipe_reg  [NSTG];
    item_t            pipe_next [NSTG];
    logic [NSTG-1:0]  vld_reg;

    // squares of the normal, eta dividend and overflow check
    always_comb
    begin
        item_t x;
        x = in_item;
        for (int i = 0; i < 3; i++)
        begin
            x.sqn[i] = 35'(36'($signed(in_item.n[i])) * 36'($signed(in_item.n[i])));
        end
        x.erem = 30'(32'(in_item.from) << FRAC_BITS) + 30'(in_item.to[14:1]);
        x.eta_sat = (in_item.to == '0) ||
                    (32'(x.erem) >= (32'(in_item.to) << ETA_STEPS));
        pipe_next[ST_IN] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_IN];
        x.sq.rem  = 44'(36'(x.sqn[0]) + 36'(x.sqn[1]) + 36'(x.sqn[2]));
        x.sq.root = '0;
        x.eta     = '0;
        pipe_next[ST_SUM] = x;
    end

    // length of the normal, with eta divided alongside
    for (genvar j = 0; j < SQ1_STEPS; j++)
    begin : g_sq1
        localparam int EB = (j < ETA_STEPS) ? ETA_STEPS - 1 - j : 0;
        always_comb
        begin
            item_t       x;
            logic [31:0] dsub;
            x = pipe_reg[SQ1_BASE + j - 1];
            x.sq = isqrt_step(x.sq, SQ1_STEPS - 1 - j);
            dsub = 32'(x.to) << EB;
            if ((j < ETA_STEPS) && (32'(x.erem) >= dsub))
            begin
                x.erem    = 30'(32'(x.erem) - dsub);
                x.eta[EB] = 1'b1;
            end
            pipe_next[SQ1_BASE + j] = x;
        end
    end

    always_comb
    begin
        item_t       x;
        logic [17:0] mag;
        x = pipe_reg[ST_NINIT - 1];
        x.zero_len = (x.sq.root == '0);
        for (int i = 0; i < 3; i++)
        begin
            mag = x.n[i][17] ? 18'(-$signed(x.n[i])) : 18'(x.n[i]);
            x.nrem[i] = (32'(mag) << FRAC_BITS) + 32'(x.sq.root[17:1]);
            x.nq[i]   = '0;
        end
        if (x.eta_sat)
        begin
            x.eta = ETA_MAX;
        end
        pipe_next[ST_NINIT] = x;
    end

    // each normal component over the length, one quotient bit per stage
    for (genvar j = 0; j < NRM_STEPS; j++)
    begin : g_nrm
        localparam int B = NRM_STEPS - 1 - j;
        always_comb
        begin
            item_t       x;
            logic [31:0] dsub;
            x = pipe_reg[NRM_BASE + j - 1];
            dsub = 32'(x.sq.root[17:0]) << B;
            for (int i = 0; i < 3; i++)
            begin
                if (x.nrem[i] >= dsub)
                begin
                    x.nrem[i]  = x.nrem[i] - dsub;
                    x.nq[i][B] = 1'b1;
                end
            end
            pipe_next[NRM_BASE + j] = x;
        end
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_NSIGN - 1];
        for (int i = 0; i < 3; i++)
        begin
            if (x.zero_len)
            begin
                x.n[i] = '0;
            end
            else if (x.n[i][17])
            begin
                x.n[i] = -$signed(18'(x.nq[i]));
            end
            else
            begin
                x.n[i] = 18'(x.nq[i]);
            end
        end
        pipe_next[ST_NSIGN] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_DOT - 1];
        for (int i = 0; i < 3; i++)
        begin
            x.prod[i] = 41'(41'($signed(x.d[i])) * 41'($signed(x.n[i])));
        end
        pipe_next[ST_DOT] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_PSUM - 1];
        x.psum = 36'($signed(x.prod[0]) + $signed(x.prod[1]) + $signed(x.prod[2]));
        pipe_next[ST_PSUM] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_DN - 1];
        x.dn = 21'(rnd_shift(64'(x.psum)));
        pipe_next[ST_DN] = x;
    end

    always_comb
    begin
        item_t              x;
        logic signed [20:0] c;
        x = pipe_reg[ST_MUL - 1];
        c = -x.dn;
        x.ee = 34'(34'(x.eta) * 34'(x.eta));
        x.cc = 38'(38'(c) * 38'(c));
        x.ec = 38'(38'($signed({1'b0, x.eta})) * 38'(c));
        for (int i = 0; i < 3; i++)
        begin
            x.prod[i] = 41'(41'(x.dn) * 41'($signed(x.n[i])));
            x.edp[i]  = 36'(36'($signed({1'b0, x.eta})) * 36'($signed(x.d[i])));
        end
        pipe_next[ST_MUL] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_RND - 1];
        x.eta2 = 21'(rnd_shift($signed(64'(x.ee))));
        x.t    = 25'(ONE - rnd_shift($signed(64'(x.cc))));
        x.ecr  = 23'(rnd_shift(64'(x.ec)));
        for (int i = 0; i < 3; i++)
        begin
            x.rfl[i] = 25'(64'($signed(x.d[i])) -
                           rnd_shift(64'($signed(x.prod[i])) <<< 1));
            x.ed[i]  = 23'(rnd_shift(64'($signed(x.edp[i]))));
        end
        pipe_next[ST_RND] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_SIN - 1];
        x.s = 46'(46'($signed({1'b0, x.eta2})) * 46'(x.t));
        pipe_next[ST_SIN] = x;
    end

    // past the critical angle: flag it on refract items and keep the radicand at zero
    always_comb
    begin
        item_t              x;
        logic signed [30:0] sin2;
        logic               big;
        logic [29:0]        rad;
        x = pipe_reg[ST_RAD - 1];
        sin2 = 31'(rnd_shift(64'(x.s)));
        big  = (64'(sin2) > ONE);
        x.tir = (x.op == OP_REFRACT) && big;
        rad = big ? '0 : 30'(32'(ONE) - 32'(sin2));
        x.sq.rem  = 44'(rad) << FRAC_BITS;
        x.sq.root = '0;
        pipe_next[ST_RAD] = x;
    end

    for (genvar j = 0; j < SQ2_STEPS; j++)
    begin : g_sq2
        always_comb
        begin
            item_t x;
            x = pipe_reg[SQ2_BASE + j - 1];
            x.sq = isqrt_step(x.sq, SQ2_STEPS - 1 - j);
            pipe_next[SQ2_BASE + j] = x;
        end
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_K - 1];
        x.k = 25'(x.ecr) - 25'($signed({1'b0, x.sq.root}));
        pipe_next[ST_K] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_KN - 1];
        for (int i = 0; i < 3; i++)
        begin
            x.prod[i] = 41'(41'(x.k) * 41'($signed(x.n[i])));
        end
        pipe_next[ST_KN] = x;
    end

    always_comb
    begin
        item_t x;
        x = pipe_reg[ST_RES - 1];
        for (int i = 0; i < 3; i++)
        begin
            x.res[i] = 27'(64'($signed(x.ed[i])) + rnd_shift(64'($signed(x.prod[i]))));
        end
        pipe_next[ST_RES] = x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign out_item = pipe_reg[NSTG-1];

`ifndef SYNTHESIS
    a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_NSIGN] |->
            (64'($signed(pipe_reg[ST_NSIGN].n[0])) <= ONE) &&
            (64'($signed(pipe_reg[ST_NSIGN].n[0])) >= -ONE) &&
            (64'($signed(pipe_reg[ST_NSIGN].n[1])) <= ONE) &&
            (64'($signed(pipe_reg[ST_NSIGN].n[1])) >= -ONE) &&
            (64'($signed(pipe_reg[ST_NSIGN].n[2])) <= ONE) &&
            (64'($signed(pipe_reg[ST_NSIGN].n[2])) >= -ONE))
        else $error("normalized normal exceeds unit length");

    a_len_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_NINIT - 1] |->
            (46'(pipe_reg[ST_NINIT - 1].sq.rem) <=
             (46'(pipe_reg[ST_NINIT - 1].sq.root) << 1)))
        else $error("normal length root is not the floor root");

    a_cos_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_K - 1] |->
            (46'(pipe_reg[ST_K - 1].sq.rem) <= (46'(pipe_reg[ST_K - 1].sq.root) << 1)))
        else $error("cosine root is not the floor root");

    a_tir_refract: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_RAD] && pipe_reg[ST_RAD].tir |-> (pipe_reg[ST_RAD].op == OP_REFRACT))
        else $error("total internal reflection flagged on a reflect item");
`endif

endmodule

// ===== rtl/ray_reflect_refract.sv =====
// Reflects or refracts one ray direction per item about a surface normal that is
// normalized on the way in. Items stream in and out at one per clock while the output
// is not held. The pipeline depth is set by the bit-per-stage square roots
// (18 stages for the normal length, 22 for the refracted cosine) and the
// 15-stage divider that normalizes the normal. When the output is held, the
// pipeline still takes items until its last stage before the output fills.
module ray_reflect_refract
    import rrr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z (18 each),
    // index_from, index_to (15 each), zero pad
    input  logic [143:0] s_axis_tdata,
    // op
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z (18 each), zero pad
    output logic [55:0]  m_axis_tdata,
    // total_internal
    output logic [0:0]   m_axis_tuser
);

    item_t       in_item;
    item_t       dp_item;
    logic        dp_vld;
    logic        dp_en;
    logic        out_en;
    vec_t        dir_next;
    logic        out_vld_reg;
    vec_t        dir_reg;
    logic        tir_reg;

    assign out_en        = !out_vld_reg || m_axis_tready;
    assign dp_en         = out_en || !dp_vld;
    assign s_axis_tready = dp_en;

    always_comb
    begin
        in_item      = '0;
        in_item.op   = s_axis_tuser[0];
        in_item.d[0] = s_axis_tdata[17:0];
        in_item.d[1] = s_axis_tdata[35:18];
        in_item.d[2] = s_axis_tdata[53:36];
        in_item.n[0] = s_axis_tdata[71:54];
        in_item.n[1] = s_axis_tdata[89:72];
        in_item.n[2] = s_axis_tdata[107:90];
        in_item.from = s_axis_tdata[122:108];
        in_item.to   = s_axis_tdata[137:123];
    end

    rrr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (dp_en),
        .in_vld   (s_axis_tvalid),
        .in_item  (in_item),
        .out_vld  (dp_vld),
        .out_item (dp_item)
    );

    // pick the result and clamp to the output range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dp_item.op == OP_REFLECT)
            begin
                dir_next[i] = sat18(64'($signed(dp_item.rfl[i])));
            end
            else if (dp_item.tir)
            begin
                dir_next[i] = dp_item.d[i];
            end
            else
            begin
                dir_next[i] = sat18(64'($signed(dp_item.res[i])));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_vld_reg <= dp_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            dir_reg <= dir_next;
            tir_reg <= dp_item.tir;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = {2'b00, dir_reg[2], dir_reg[1], dir_reg[0]};
    assign m_axis_tuser[0] = tir_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rrr_pkg::*;

    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    DRAIN_CYCLES   = 100;
    localparam int    RANDOM_ITEMS   = 2000;
    localparam int    QUIET_ITEMS    = 300;
    localparam longint UNIT          = 64'sd1 << FRAC_BITS;

    typedef struct {
        logic        op;
        logic [17:0] d [3];
        logic [17:0] n [3];
        logic [14:0] from;
        logic [14:0] to;
    } ray_t;

    typedef struct {
        logic [17:0] v [3];
        logic        tir;
    } bent_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int  errors;
    int  refracted;
    int  tir_seen;
    bit  quiet;
    bit  hold_out;

    ray_reflect_refract dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic longint sx18(input logic [17:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_frac(input longint v);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (UNIT >>> 1)) >>> FRAC_BITS;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = num < 0 ? -num : num;
        mag = (mag + den / 2) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic bent_t bend_ray(input ray_t r);
        bent_t  o;
        longint d [3];
        longint n [3];
        longint res [3];
        longint sq, dn, len, c, eta, eta2, sin2, rad, cos_t, k;
        sq = 0;
        dn = 0;
        o.tir = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = sx18(r.d[i]);
            n[i] = sx18(r.n[i]);
            sq += n[i] * n[i];
        end
        if (sq != UNIT * UNIT)
        begin
            len = floor_sqrt(sq);
            for (int i = 0; i < 3; i++)
                n[i] = (len == 0) ? 0 : round_div(n[i] * UNIT, len);
        end
        for (int i = 0; i < 3; i++)
            dn += d[i] * n[i];
        dn = round_frac(dn);
        if (r.op == OP_REFLECT)
        begin
            for (int i = 0; i < 3; i++)
                res[i] = d[i] - round_frac(2 * dn * n[i]);
        end
        else
        begin
            c = -dn;
            eta = (r.to == 0) ? 131071
                : clampl(round_div(longint'(r.from) * UNIT, longint'(r.to)), 0, 131071);
            eta2 = round_frac(eta * eta);
            sin2 = round_frac(eta2 * (UNIT - round_frac(c * c)));
            if (sin2 > UNIT)
            begin
                o.tir = 1'b1;
                for (int i = 0; i < 3; i++)
                    res[i] = d[i];
            end
            else
            begin
                rad = clampl(UNIT - sin2, 0, 64'sd1 <<< 38);
                cos_t = floor_sqrt(rad <<< FRAC_BITS);
                k = clampl(round_frac(eta * c) - cos_t, -(64'sd1 <<< 30), 64'sd1 <<< 30);
                for (int i = 0; i < 3; i++)
                    res[i] = round_frac(eta * d[i]) + round_frac(k * n[i]);
            end
        end
        for (int i = 0; i < 3; i++)
            o.v[i] = 18'(clampl(res[i], -131072, 131071));
        return o;
    endfunction

    class ray_scoreboard;
        bent_t pending [$];

        function void note_ray(input ray_t r);
            pending.push_back(bend_ray(r));
        endfunction

        task check_ray(input logic [55:0] data, input logic tir);
            bent_t want;
            if (pending.size() == 0)
            begin
                report("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++)
                if (data[18*i +: 18] !== want.v[i])
                    report($sformatf("out component %0d", i),
                           sx18(data[18*i +: 18]), sx18(want.v[i]));
            if (data[55:54] !== 2'b00)
                report("pad bits", data[55:54], 0);
            if (tir !== want.tir)
                report("total_internal", tir, want.tir);
            else if (tir)
                tir_seen++;
        endtask
    endclass

    ray_scoreboard board;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [17:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'(UNIT);
            3: return 18'(-UNIT);
            default: return 18'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
        endcase
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        r.op = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++)
        begin
            r.d[i] = ($urandom_range(0, 7) == 0) ? 18'($urandom) : pick_comp();
            r.n[i] = ($urandom_range(0, 7) == 0) ? 18'($urandom) : pick_comp();
        end
        if ($urandom_range(0, 9) == 0)
            r.n = '{18'd0, 18'd0, 18'd0};
        else if ($urandom_range(0, 5) == 0)
            r.n = '{18'd0, 18'(UNIT), 18'd0};
        r.from = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
        r.to = ($urandom_range(0, 19) == 0) ? 15'd0
             : ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
        return r;
    endfunction

    task automatic send_ray(input ray_t r);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {2'b00, r.to, r.from, r.n[2], r.n[1], r.n[0], r.d[2], r.d[1], r.d[0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_ray(r);
        if (r.op == OP_REFRACT)
            refracted++;
    endtask

    task automatic send_directed();
        ray_t r;
        for (int k = 0; k < 24; k++)
        begin
            r.op = k[0];
            r.d = '{18'(k[1] ? -UNIT : UNIT / 2), 18'(UNIT / 3), 18'(-UNIT / 2)};
            r.n = '{18'd0, 18'(UNIT), 18'd0};
            r.from = 15'd8192;
            r.to = 15'd12288;
            case (k / 2)
                0: ;
                1: r.n = '{18'd0, 18'd0, 18'd0};
                2: r.to = 15'd0;
                3: begin r.from = 15'd32767; r.to = 15'd8192; end
                4: r.d = '{18'h1FFFF, 18'h1FFFF, 18'h1FFFF};
                5: r.d = '{18'h20000, 18'h20000, 18'h20000};
                6: r.n = '{18'h1FFFF, 18'h20000, 18'h1FFFF};
                7: r.n = '{18'd3, 18'd0, 18'd0};
                8: begin r.from = 15'h7FFF; r.to = 15'd1; end
                9: begin r.from = 15'd0; r.to = 15'h7FFF; end
                10: r.d = '{18'(UNIT), 18'd1, 18'd0};
                default: r = random_ray();
            endcase
            send_ray(r);
        end
    endtask

    // output side: random stalls, one long hold, none in the quiet tail
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_out = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_ray(m_axis_tdata, m_axis_tuser[0]);

    // watchdog on cycles without any handshake
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d idle cycles", idle);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        board = new();
        errors = 0;
        refracted = 0;
        tir_seen = 0;
        quiet = 1'b0;
        hold_out = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 200)
                hold_out = 1'b1;
            if (k == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_ray(random_ray());
        end
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered reflect and refract rays, %0d refracted, %0d total internal",
                 refracted, tir_seen);
        if (errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rrr_pkg.sv
rtl/rrr_datapath.sv
rtl/ray_reflect_refract.sv
bench/testbench.sv
